FILE: rtl/srsw_pkg.sv
// Shared types, constants and the slot lookup table of the selective-repeat sender window.
`default_nettype none

package srsw_pkg;

    // Fixed field widths
    localparam int SEQ_W        = 8;
    localparam int IN_PAYLOAD_W = 32;
    localparam int S_TDATA_W    = 56;
    localparam int M_TDATA_W    = 56;
    localparam int CMD_W        = 2;

    // Parameter defaults
    localparam int WINDOW_DEF       = 4;
    localparam int RING_SLOTS_DEF   = 8;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Slot index table entry width (enough for 128 slots)
    localparam int LUT_W   = 7;
    localparam int SEQ_NUM = 256;

    // Command codes on s_tuser
    localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        OP_SEND,
        OP_ACK,
        OP_TIMEOUT,
        OP_IGNORE
    } op_t;

    typedef enum logic [1:0] {
        TMR_NONE    = 2'd0,
        TMR_START   = 2'd1,
        TMR_STOP    = 2'd2,
        TMR_RESTART = 2'd3
    } timer_act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SLIDE,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        op_t                     op;
        logic [SEQ_W-1:0]        seq;
        logic [IN_PAYLOAD_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic                    window_full;
        logic [SEQ_W-1:0]        timer_seq;
        timer_act_t              timer_action;
        logic [IN_PAYLOAD_W-1:0] packet_payload;
        logic [SEQ_W-1:0]        packet_seq;
        logic                    packet_valid;
        logic                    accepted;
    } result_t;

    typedef logic [SEQ_NUM-1:0][LUT_W-1:0] slot_lut_t;

    // Sequence number to ring slot, built by counting so no divider is needed
    function automatic slot_lut_t build_slot_lut(input int slots);
        slot_lut_t lut;
        int        k;
        lut = '0;
        k   = 0;
        for (int i = 0; i < SEQ_NUM; i++) begin
            lut[i] = LUT_W'(k);
            k      = (k == slots - 1) ? 0 : k + 1;
        end
        return lut;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/selective_repeat_sender_window_unit.sv
// Top level of the selective-repeat sender window: front end, command queue, window back end.
//
// Input channel s_*: one command per transfer, kind on s_tuser (0 send, 1 ack,
// 2 timer expired). Result channel m_*: exactly one result transfer per input
// transfer, in order. A two-entry queue between the front end and the window
// sequencer lets input transfers be taken while the sequencer works or the
// result register waits for m_tready.
// A command passes through the queue, the execute state and the done state
// before it reaches the result register; a timeout adds a read state for the
// registered read port of the payload ring, and an ack of the window base adds
// a slide state in which the base slides one slot per cycle over the released
// slots (at most WINDOW). The sequencer handles one command at a time.
// Reset (aresetn low, synchronous) clears window base, next sequence, full flag
// and all acked bits, and empties the queue; ring payloads stay unwritten.
// While m_tready is low the result holds; once the queue fills, s_tready drops.
`default_nettype none

module selective_repeat_sender_window_unit
    import srsw_pkg::*;
#(
    parameter int WINDOW       = WINDOW_DEF,
    parameter int RING_SLOTS   = RING_SLOTS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // payload[31:0], ack_number[39:32], ack_intact[40], expired_seq[48:41], zero fill
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  wire logic [CMD_W-1:0]     s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // accepted[0], packet_valid[1], packet_seq[9:2], packet_payload[41:10],
    // timer_action[43:42], timer_seq[51:44], window_full[52], zero fill
    output logic [M_TDATA_W-1:0]      m_tdata
);

    logic    q_push, q_pop, q_full, q_empty;
    entry_t  q_entry, q_head;
    result_t result;

    srsw_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    srsw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    srsw_back #(
        .WINDOW       (WINDOW),
        .RING_SLOTS   (RING_SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_result (result)
    );

    assign m_tdata = {3'b000, result.window_full, result.timer_seq, result.timer_action,
                      result.packet_payload, result.packet_seq, result.packet_valid,
                      result.accepted};

endmodule

`default_nettype wire

FILE: rtl/srsw_front.sv
// Front end: unpacks an incoming transfer and classifies it into a queue entry.
`default_nettype none

module srsw_front
    import srsw_pkg::*;
(
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [CMD_W-1:0]     s_tuser,
    input  wire logic                 q_full,
    output logic                      q_push,
    output entry_t                    q_entry
);

    logic [IN_PAYLOAD_W-1:0] payload;
    logic [SEQ_W-1:0]        ack_number;
    logic                    ack_intact;
    logic [SEQ_W-1:0]        expired_seq;

    assign payload     = s_tdata[31:0];
    assign ack_number  = s_tdata[39:32];
    assign ack_intact  = s_tdata[40];
    assign expired_seq = s_tdata[48:41];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_entry.payload = payload;
        q_entry.seq     = '0;
        case (s_tuser)
            CMD_SEND: begin
                q_entry.op = OP_SEND;
            end
            CMD_ACK: begin
                // corrupt acks are dropped here
                q_entry.op  = ack_intact ? OP_ACK : OP_IGNORE;
                q_entry.seq = ack_number;
            end
            CMD_TIMEOUT: begin
                q_entry.op  = OP_TIMEOUT;
                q_entry.seq = expired_seq;
            end
            default: begin
                q_entry.op = OP_IGNORE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/srsw_queue.sv
// Short command queue decoupling the front end from the window sequencer.
`default_nettype none

module srsw_queue
    import srsw_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output entry_t      head,
    output logic        full,
    output logic        empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/srsw_back.sv
// Back end: window state, payload ring memory, base slide sequencer and result register.
`default_nettype none

module srsw_back
    import srsw_pkg::*;
#(
    parameter int WINDOW       = WINDOW_DEF,
    parameter int RING_SLOTS   = RING_SLOTS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   q_empty,
    input  wire entry_t q_head,
    output logic        q_pop,
    input  wire logic   m_tready,
    output logic        m_tvalid,
    output result_t     m_result
);

    localparam int               SLOT_W   = $clog2(RING_SLOTS);
    localparam logic [SEQ_W-1:0] WIN_SEQ  = SEQ_W'(WINDOW);
    localparam slot_lut_t        SLOT_LUT = build_slot_lut(RING_SLOTS);

    back_state_t              state_reg, state_next;
    entry_t                   cur_reg, cur_next;
    result_t                  res_reg, res_next;
    result_t                  m_res_reg, m_res_next;
    logic                     m_valid_reg, m_valid_next;
    logic [SEQ_W-1:0]         base_reg, base_next;
    logic [SEQ_W-1:0]         next_seq_reg, next_seq_next;
    logic                     full_reg, full_next;
    logic [RING_SLOTS-1:0]    acked_reg, acked_next;
    logic [SEQ_W-1:0]         out_cnt_reg, out_cnt_next;
    logic [SEQ_W-1:0]         slide_cnt_reg, slide_cnt_next;

    // payload ring
    logic [PAYLOAD_BITS-1:0]  ring_mem [RING_SLOTS];
    logic [PAYLOAD_BITS-1:0]  rd_data_reg;
    logic [PAYLOAD_BITS-1:0]  wr_data;
    logic                     mem_we;
    logic [SLOT_W-1:0]        wr_slot, cur_slot, base_slot;

    logic [SEQ_W-1:0]         out_cnt, ack_dist;

    assign out_cnt   = SEQ_W'(next_seq_reg - base_reg);
    assign ack_dist  = SEQ_W'(cur_reg.seq - base_reg);
    assign wr_slot   = SLOT_LUT[next_seq_reg][SLOT_W-1:0];
    assign cur_slot  = SLOT_LUT[cur_reg.seq][SLOT_W-1:0];
    assign base_slot = SLOT_LUT[base_reg][SLOT_W-1:0];
    assign wr_data   = PAYLOAD_BITS'(cur_reg.payload);

    assign m_tvalid = m_valid_reg;
    assign m_result = m_res_reg;

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        m_res_next     = m_res_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        base_next      = base_reg;
        next_seq_next  = next_seq_reg;
        full_next      = full_reg;
        acked_next     = acked_reg;
        out_cnt_next   = out_cnt_reg;
        slide_cnt_next = slide_cnt_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cur_next   = q_head;
                    res_next   = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                case (cur_reg.op)
                    OP_SEND: begin
                        if (!full_reg && out_cnt < WIN_SEQ) begin
                            mem_we                  = 1'b1;
                            acked_next[wr_slot]     = 1'b0;
                            res_next.accepted       = 1'b1;
                            res_next.packet_valid   = 1'b1;
                            res_next.packet_seq     = next_seq_reg;
                            res_next.packet_payload = IN_PAYLOAD_W'(wr_data);
                            res_next.timer_action   = TMR_START;
                            res_next.timer_seq      = next_seq_reg;
                            next_seq_next           = SEQ_W'(next_seq_reg + 1'b1);
                            if (SEQ_W'(out_cnt + 1'b1) >= WIN_SEQ) begin
                                full_next = 1'b1;
                            end
                        end
                    end
                    OP_ACK: begin
                        if (ack_dist < out_cnt) begin
                            if (ack_dist == '0) begin
                                acked_next[cur_slot]  = 1'b1;
                                res_next.timer_action = TMR_STOP;
                                res_next.timer_seq    = cur_reg.seq;
                                out_cnt_next          = out_cnt;
                                slide_cnt_next        = '0;
                                state_next            = ST_SLIDE;
                            end else if (!acked_reg[cur_slot]) begin
                                acked_next[cur_slot]  = 1'b1;
                                res_next.timer_action = TMR_STOP;
                                res_next.timer_seq    = cur_reg.seq;
                            end
                        end
                    end
                    OP_TIMEOUT: begin
                        res_next.packet_valid = 1'b1;
                        res_next.packet_seq   = cur_reg.seq;
                        res_next.timer_action = TMR_RESTART;
                        res_next.timer_seq    = cur_reg.seq;
                        state_next            = ST_READ;
                    end
                    default: begin
                    end
                endcase
            end
            ST_READ: begin
                res_next.packet_payload = IN_PAYLOAD_W'(rd_data_reg);
                state_next              = ST_DONE;
            end
            ST_SLIDE: begin
                // release one acked slot per cycle, never past next_seq
                if (slide_cnt_reg < out_cnt_reg && acked_reg[base_slot]) begin
                    acked_next[base_slot] = 1'b0;
                    base_next             = SEQ_W'(base_reg + 1'b1);
                    slide_cnt_next        = SEQ_W'(slide_cnt_reg + 1'b1);
                end else begin
                    full_next  = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_res_next             = res_reg;
                    m_res_next.window_full = full_reg;
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            base_reg     <= '0;
            next_seq_reg <= '0;
            full_reg     <= 1'b0;
            acked_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            base_reg     <= base_next;
            next_seq_reg <= next_seq_next;
            full_reg     <= full_next;
            acked_reg    <= acked_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        res_reg       <= res_next;
        m_res_reg     <= m_res_next;
        out_cnt_reg   <= out_cnt_next;
        slide_cnt_reg <= slide_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wr_slot] <= wr_data;
        end
        rd_data_reg <= ring_mem[cur_slot];
    end

`ifndef SYNTHESIS
    a_outstanding_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt <= WIN_SEQ)
        else $error("more packets outstanding than the window allows");

    // the flag drops only when the slide ends, so the base may move under it
    a_full_means_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (full_reg && state_reg != ST_SLIDE) |-> (out_cnt == WIN_SEQ))
        else $error("full flag set with window not full");

    a_slide_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SLIDE) |-> (slide_cnt_reg <= out_cnt_reg))
        else $error("base slid past next sequence");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_tready)) |=>
            (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished item did not reach the output register");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the selective-repeat sender window unit.
`timescale 1ns / 100ps

module testbench
    import srsw_pkg::*;
();

    localparam int WINDOW       = WINDOW_DEF;
    localparam int RING_SLOTS   = RING_SLOTS_DEF;
    localparam int ITEMS_PER_PHASE = 410;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [IN_PAYLOAD_W-1:0] payload;
        logic [SEQ_W-1:0]        ack_number;
        logic                    ack_intact;
        logic [SEQ_W-1:0]        expired_seq;
    } cmd_item_t;

    typedef struct packed {
        logic [RING_SLOTS-1:0][IN_PAYLOAD_W-1:0] payload;
        logic [RING_SLOTS-1:0]                   acked;
        logic [RING_SLOTS-1:0]                   written;
        logic [SEQ_W-1:0]                        base;
        logic [SEQ_W-1:0]                        next_seq;
        logic                                    full;
        result_t                                 res;
    } window_state_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    cmd_item_t     pending_cmds[$];
    result_t       expected_results[$];
    cmd_item_t     cur_item;
    window_state_t gen_state = '0;
    window_state_t dut_state = '0;
    int            send_idle = 0;
    int            recv_idle = 0;
    int            errors    = 0;
    int            stall_cycles = 0;

    selective_repeat_sender_window_unit #(
        .WINDOW       (WINDOW),
        .RING_SLOTS   (RING_SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS_DEF)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Advances the window by one command; the result lands in .res
    function automatic window_state_t window_step(window_state_t st, cmd_item_t it);
        logic [SEQ_W-1:0] outs;
        logic [SEQ_W-1:0] ack_dist;
        logic [SEQ_W-1:0] s;
        int               n;
        st.res = '0;
        outs = st.next_seq - st.base;
        case (it.cmd)
            CMD_SEND: begin
                if (!st.full && outs < WINDOW) begin
                    s = st.next_seq;
                    st.payload[s % RING_SLOTS] = it.payload;
                    st.acked[s % RING_SLOTS]   = 1'b0;
                    st.written[s % RING_SLOTS] = 1'b1;
                    st.res.accepted       = 1'b1;
                    st.res.packet_valid   = 1'b1;
                    st.res.packet_seq     = s;
                    st.res.packet_payload = it.payload;
                    st.res.timer_action   = TMR_START;
                    st.res.timer_seq      = s;
                    st.next_seq = s + 1'b1;
                    outs = st.next_seq - st.base;
                    if (outs >= WINDOW)
                        st.full = 1'b1;
                end
            end
            CMD_ACK: begin
                ack_dist = it.ack_number - st.base;
                if (it.ack_intact && ack_dist < outs) begin
                    if (ack_dist == 0) begin
                        st.acked[it.ack_number % RING_SLOTS] = 1'b1;
                        n = 0;
                        // slide past every acked slot, never beyond next_seq
                        while (n < outs && st.acked[st.base % RING_SLOTS]) begin
                            st.acked[st.base % RING_SLOTS] = 1'b0;
                            st.base = st.base + 1'b1;
                            n++;
                        end
                        st.full = 1'b0;
                        st.res.timer_action = TMR_STOP;
                        st.res.timer_seq    = it.ack_number;
                    end else if (!st.acked[it.ack_number % RING_SLOTS]) begin
                        st.acked[it.ack_number % RING_SLOTS] = 1'b1;
                        st.res.timer_action = TMR_STOP;
                        st.res.timer_seq    = it.ack_number;
                    end
                end
            end
            CMD_TIMEOUT: begin
                st.res.packet_valid   = 1'b1;
                st.res.packet_seq     = it.expired_seq;
                st.res.packet_payload = st.payload[it.expired_seq % RING_SLOTS];
                st.res.timer_action   = TMR_RESTART;
                st.res.timer_seq      = it.expired_seq;
            end
            default: ;
        endcase
        st.res.window_full = st.full;
        return st;
    endfunction

    task automatic queue_item(logic [CMD_W-1:0] cmd, logic [IN_PAYLOAD_W-1:0] payload,
                              logic [SEQ_W-1:0] ack_number, logic ack_intact,
                              logic [SEQ_W-1:0] expired_seq);
        cmd_item_t it;
        it = '{cmd, payload, ack_number, ack_intact, expired_seq};
        pending_cmds.push_back(it);
        gen_state = window_step(gen_state, it);
    endtask

    task automatic add_directed();
        queue_item(CMD_ACK,     32'h0000_0000, 8'h00, 1'b1, 8'h00); // nothing outstanding
        queue_item(CMD_UNUSED,  32'hFFFF_FFFF, 8'hFF, 1'b1, 8'hFF);
        queue_item(CMD_SEND,    32'h0000_0000, 8'hFF, 1'b1, 8'hFF);
        queue_item(CMD_SEND,    32'hFFFF_FFFF, 8'h00, 1'b0, 8'h00);
        queue_item(CMD_SEND,    32'hA5A5_A5A5, 8'h00, 1'b0, 8'h00);
        queue_item(CMD_SEND,    32'h5A5A_5A5A, 8'h00, 1'b0, 8'h00); // window fills
        queue_item(CMD_SEND,    32'h1234_5678, 8'h00, 1'b0, 8'h00); // refused
        queue_item(CMD_TIMEOUT, 32'h0000_0000, 8'h00, 1'b0, 8'h01);
        queue_item(CMD_ACK,     32'h0000_0000, 8'h02, 1'b1, 8'h00); // above base
        queue_item(CMD_ACK,     32'h0000_0000, 8'h02, 1'b1, 8'h00); // duplicate
        queue_item(CMD_ACK,     32'h0000_0000, 8'h00, 1'b0, 8'h00); // corrupt
        queue_item(CMD_ACK,     32'h0000_0000, 8'h00, 1'b1, 8'h00); // base, clears full
        queue_item(CMD_ACK,     32'h0000_0000, 8'h03, 1'b1, 8'h00);
        queue_item(CMD_ACK,     32'h0000_0000, 8'h01, 1'b1, 8'h00); // slides to next_seq
        queue_item(CMD_ACK,     32'h0000_0000, 8'h04, 1'b1, 8'h00); // not outstanding
        queue_item(CMD_SEND,    32'hFFFF_FFFF, 8'h00, 1'b0, 8'h00);
        queue_item(CMD_ACK,     32'h0000_0000, 8'hFF, 1'b1, 8'h00); // far outside window
        queue_item(CMD_TIMEOUT, 32'h0000_0000, 8'h00, 1'b0, 8'h08); // unsent seq, same slot as seq 0
        queue_item(CMD_TIMEOUT, 32'hFFFF_FFFF, 8'hFF, 1'b1, 8'h04);
        queue_item(CMD_UNUSED,  32'h0000_0000, 8'h00, 1'b0, 8'h00);
        queue_item(CMD_ACK,     32'h0000_0000, 8'h04, 1'b1, 8'h00);
    endtask

    // Mostly well-formed traffic: sends, acks of outstanding seqs and timeouts, plus noise
    task automatic add_random_item();
        logic [SEQ_W-1:0] outs;
        int               r;
        cmd_item_t        it;
        outs = gen_state.next_seq - gen_state.base;
        it.payload     = ($urandom_range(9) == 0) ? {32{$urandom_range(1) == 1}} : $urandom;
        it.ack_number  = SEQ_W'($urandom_range(255));
        it.ack_intact  = 1'($urandom_range(1));
        it.expired_seq = SEQ_W'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 40 || (r >= 75 && r < 87 && gen_state.written == '0)) begin
            it.cmd = CMD_SEND;
        end else if (r < 75) begin
            it.cmd = CMD_ACK;
            if (outs != 0) begin
                it.ack_number = SEQ_W'(gen_state.base +
                    (($urandom_range(2) == 0) ? 0 : $urandom_range(outs - 1)));
                it.ack_intact = ($urandom_range(9) != 0);
            end
        end else if (r < 87) begin
            it.cmd = CMD_TIMEOUT;
            if (outs != 0 && $urandom_range(1) == 1)
                it.expired_seq = SEQ_W'(gen_state.base + $urandom_range(outs - 1));
            else
                while (!gen_state.written[it.expired_seq % RING_SLOTS])
                    it.expired_seq = it.expired_seq + 1'b1;
        end else if (r < 95) begin
            it.cmd = CMD_ACK;
        end else begin
            it.cmd = CMD_UNUSED;
        end
        queue_item(it.cmd, it.payload, it.ack_number, it.ack_intact, it.expired_seq);
    endtask

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
            errors++;
        end
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                dut_state = window_step(dut_state, cur_item);
                expected_results.push_back(dut_state.res);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle) begin
                    cur_item = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, cur_item.expired_seq, cur_item.ack_intact,
                                 cur_item.ack_number, cur_item.payload};
                    s_tuser  <= cur_item.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        result_t act;
        result_t exp_res;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                act = m_tdata[$bits(result_t)-1:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, act);
                    errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    check_field("accepted",       32'(exp_res.accepted),
                                32'(act.accepted));
                    check_field("packet_valid",   32'(exp_res.packet_valid),
                                32'(act.packet_valid));
                    check_field("packet_seq",     32'(exp_res.packet_seq),
                                32'(act.packet_seq));
                    check_field("packet_payload", exp_res.packet_payload, act.packet_payload);
                    check_field("timer_action",   32'(exp_res.timer_action),
                                32'(act.timer_action));
                    check_field("timer_seq",      32'(exp_res.timer_seq),
                                32'(act.timer_seq));
                    check_field("window_full",    32'(exp_res.window_full),
                                32'(act.window_full));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Cycles without any transfer on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        for (int phase = 0; phase < 3; phase++) begin
            @(negedge aclk);
            send_idle = (phase == 0) ? 36 : (phase == 1) ? 73 : 0;
            recv_idle = (phase == 0) ? 73 : (phase == 1) ? 36 : 0;
            if (phase == 0)
                add_directed();
            repeat (ITEMS_PER_PHASE) add_random_item();
            // the next phase starts only once every result of this phase has arrived
            while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
                @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
